[hdl/sgt_pkg.sv]
package sgt_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned GRAY_FRAC_DEF  = 12;

  localparam int unsigned PIXEL_W        = 8;
  localparam int unsigned OUT_W          = 23;
  localparam int unsigned ROW_W          = 12;
  localparam int unsigned DIM_W          = 13;
  localparam int unsigned WIDTH_REG_W    = 11;
  localparam int unsigned HEIGHT_REG_W   = 13;
  localparam int unsigned THRESH_W       = 11;
  localparam int unsigned MIN_DIM        = 3;
  localparam int unsigned MAX_HEIGHT     = 4096;

  localparam int unsigned APB_ADDR_W     = 4;
  localparam int unsigned APB_DATA_W     = 32;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [THRESH_W-1:0]     THRESH_RESET = 11'd200;

  // register indexes, byte address is 4 * index
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  // luma weights in units of 1/10000
  localparam int unsigned WEIGHT_R = 2125;
  localparam int unsigned WEIGHT_G = 7154;
  localparam int unsigned WEIGHT_B = 721;

  typedef struct packed {
    logic [WIDTH_REG_W-1:0]  width;
    logic [HEIGHT_REG_W-1:0] height;
    logic [THRESH_W-1:0]     threshold;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WIN,
    S_GRAD,
    S_SQUARE,
    S_SUM,
    S_ROOT,
    S_DONE
  } state_e;

  // round weight / 10000 to the nearest step of 2^-frac_bits
  function automatic int unsigned gray_coef(int unsigned weight, int unsigned frac_bits);
    longint unsigned scaled;
    scaled = 64'(weight) * (64'd1 << frac_bits) + 64'd5000;
    return 32'(scaled / 64'd10000);
  endfunction

endpackage

[hdl/sgt_line_mem.sv]
module sgt_line_mem #(
  parameter int unsigned DEPTH  = sgt_pkg::MAX_WIDTH_DEF,
  parameter int unsigned DATA_W = 40
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]        rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]        wr_data_i
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

[hdl/sgt_sqrt.sv]
module sgt_sqrt #(
  parameter int unsigned ROOT_W = 23
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [2*ROOT_W-1:0]   value_i,
  output logic                  done_o,
  output logic [ROOT_W-1:0]     root_o
);

  localparam int unsigned VAL_W = 2 * ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

  logic [VAL_W-1:0]  val_q, val_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;

  logic [REM_W+1:0]  rem_t;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              fits;

  // one result bit per step: bring down two bits, try root*4+1
  always_comb begin
    rem_t = {rem_q, val_q[VAL_W-1 -: 2]};
    trial = {2'b00, root_q, 2'b01};
    fits  = rem_t >= trial;
    diff  = rem_t - trial;
  end

  always_comb begin
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      val_d  = value_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNT_W'(ROOT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        val_d  = {val_q[VAL_W-3:0], 2'b00};
        rem_d  = fits ? REM_W'(diff) : REM_W'(rem_t);
        root_d = {root_q[ROOT_W-2:0], fits};
        cnt_d  = cnt_q - 1'b1;
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign root_o = root_q;

`ifndef ASSERT_OFF
  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rem_q <= {1'b0, root_q, 1'b0})
    else $error("square root remainder exceeds twice the root");
`endif

endmodule

[hdl/sgt_apb_regs.sv]
module sgt_apb_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sgt_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [sgt_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [sgt_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output sgt_pkg::cfg_t                    cfg_o
);

  sgt_pkg::cfg_t cfg_q, cfg_d;
  logic [1:0]    idx;
  logic          wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        sgt_pkg::REG_WIDTH:  cfg_d.width     = pwdata[sgt_pkg::WIDTH_REG_W-1:0];
        sgt_pkg::REG_HEIGHT: cfg_d.height    = pwdata[sgt_pkg::HEIGHT_REG_W-1:0];
        sgt_pkg::REG_THRESH: cfg_d.threshold = pwdata[sgt_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sgt_pkg::REG_WIDTH:  prdata = sgt_pkg::APB_DATA_W'(cfg_q.width);
      sgt_pkg::REG_HEIGHT: prdata = sgt_pkg::APB_DATA_W'(cfg_q.height);
      sgt_pkg::REG_THRESH: prdata = sgt_pkg::APB_DATA_W'(cfg_q.threshold);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width     <= sgt_pkg::WIDTH_RESET;
      cfg_q.height    <= sgt_pkg::HEIGHT_RESET;
      cfg_q.threshold <= sgt_pkg::THRESH_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/sobel_gradient_threshold_top.sv]
// Channel | Dir | Handshake                  | Payload
// pixel   | in  | in_valid_i / in_ready_o    | red_i, green_i, blue_i
// result  | out | out_valid_o / out_ready_i  | horizontal_gradient_o, vertical_gradient_o,
//         |     |                            | edge_magnitude_o, frame_last_o
// config  | in  | APB psel/penable, pready=1 | paddr, pwdata, prdata
//
// A border pixel is accepted with a line store read, then shifts the window and is written back.
// An interior pixel goes on through gradient, square, sum and root steps, the root paced by the
// one-bit-per-cycle square root unit; the next pixel is taken while the result waits.
// A result waiting on out_ready_i holds the block at its last step until taken.
// Reset clears counters, window, state and config registers; line stores and data registers are not cleared.
module sobel_gradient_threshold_top #(
  parameter int unsigned MAX_WIDTH          = sgt_pkg::MAX_WIDTH_DEF,
  parameter int unsigned GRAY_FRACTION_BITS = sgt_pkg::GRAY_FRAC_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sgt_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [sgt_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [sgt_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [sgt_pkg::PIXEL_W-1:0]           red_i,
  input  logic [sgt_pkg::PIXEL_W-1:0]           green_i,
  input  logic [sgt_pkg::PIXEL_W-1:0]           blue_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [sgt_pkg::OUT_W-1:0]      horizontal_gradient_o,
  output logic signed [sgt_pkg::OUT_W-1:0]      vertical_gradient_o,
  output logic [sgt_pkg::OUT_W-1:0]             edge_magnitude_o,
  output logic                                  frame_last_o
);

  localparam int unsigned GRAY_W = sgt_pkg::PIXEL_W + GRAY_FRACTION_BITS;
  localparam int unsigned GRAD_W = GRAY_W + 3;
  localparam int unsigned SQ_W   = 2 * GRAD_W;
  localparam int unsigned CW     = $clog2(MAX_WIDTH);
  localparam int unsigned DIM_W  = sgt_pkg::DIM_W;
  localparam int unsigned COEF_R = sgt_pkg::gray_coef(sgt_pkg::WEIGHT_R, GRAY_FRACTION_BITS);
  localparam int unsigned COEF_G = sgt_pkg::gray_coef(sgt_pkg::WEIGHT_G, GRAY_FRACTION_BITS);
  localparam int unsigned COEF_B = sgt_pkg::gray_coef(sgt_pkg::WEIGHT_B, GRAY_FRACTION_BITS);

  sgt_pkg::cfg_t   cfg;
  sgt_pkg::state_e state_q, state_d;

  sgt_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // effective frame geometry
  logic [DIM_W-1:0] w_last, h_last;

  always_comb begin
    if (cfg.width < sgt_pkg::MIN_DIM) begin
      w_last = DIM_W'(sgt_pkg::MIN_DIM - 1);
    end else if (cfg.width > MAX_WIDTH) begin
      w_last = DIM_W'(MAX_WIDTH - 1);
    end else begin
      w_last = DIM_W'(cfg.width) - DIM_W'(1);
    end
    if (cfg.height < sgt_pkg::MIN_DIM) begin
      h_last = DIM_W'(sgt_pkg::MIN_DIM - 1);
    end else if (cfg.height > sgt_pkg::MAX_HEIGHT) begin
      h_last = DIM_W'(sgt_pkg::MAX_HEIGHT - 1);
    end else begin
      h_last = DIM_W'(cfg.height) - DIM_W'(1);
    end
  end

  logic                       accept;
  logic                       col_last, row_last, has_result;
  logic [CW-1:0]              col_q, col_d;
  logic [sgt_pkg::ROW_W-1:0]  row_q, row_d;

  assign accept     = in_valid_i && in_ready_o;
  assign col_last   = DIM_W'(col_q) >= w_last;
  assign row_last   = DIM_W'(row_q) >= h_last;
  assign has_result = (col_q >= 2) && (row_q >= 2);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  // pixel request registers
  logic [sgt_pkg::PIXEL_W-1:0] red_q, green_q, blue_q;
  logic [CW-1:0]               addr_q;
  logic                        result_q, result_d;
  logic                        last_q;

  assign result_d = accept ? has_result : result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      result_q <= 1'b0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
      addr_q  <= col_q;
      last_q  <= col_last && row_last;
    end
  end

  logic [GRAY_W-1:0] gray;

  assign gray = GRAY_W'(red_q) * GRAY_W'(COEF_R) + GRAY_W'(green_q) * GRAY_W'(COEF_G)
              + GRAY_W'(blue_q) * GRAY_W'(COEF_B);

  // line word: upper half two rows up, lower half one row up
  logic [2*GRAY_W-1:0] line_rd;
  logic                mem_we;

  sgt_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2 * GRAY_W)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (line_rd),
    .wr_en_i   (mem_we),
    .wr_addr_i (addr_q),
    .wr_data_i ({line_rd[GRAY_W-1:0], gray})
  );

  logic [GRAY_W-1:0] win_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (mem_we) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= line_rd[2*GRAY_W-1:GRAY_W];
      win_q[1][2] <= line_rd[GRAY_W-1:0];
      win_q[2][2] <= gray;
    end
  end

  // Sobel kernels, weights 1,2,1
  logic [GRAD_W-1:0] left_sum, right_sum, top_sum, bottom_sum;

  always_comb begin
    left_sum   = GRAD_W'(win_q[0][0]) + (GRAD_W'(win_q[1][0]) << 1) + GRAD_W'(win_q[2][0]);
    right_sum  = GRAD_W'(win_q[0][2]) + (GRAD_W'(win_q[1][2]) << 1) + GRAD_W'(win_q[2][2]);
    top_sum    = GRAD_W'(win_q[0][0]) + (GRAD_W'(win_q[0][1]) << 1) + GRAD_W'(win_q[0][2]);
    bottom_sum = GRAD_W'(win_q[2][0]) + (GRAD_W'(win_q[2][1]) << 1) + GRAD_W'(win_q[2][2]);
  end

  logic signed [GRAD_W-1:0] gx_q, gy_q;
  logic [GRAD_W-2:0]        abs_x, abs_y;
  logic [SQ_W-1:0]          sqx_q, sqy_q;

  assign abs_x = gx_q[GRAD_W-1] ? (GRAD_W-1)'(-gx_q) : (GRAD_W-1)'(gx_q);
  assign abs_y = gy_q[GRAD_W-1] ? (GRAD_W-1)'(-gy_q) : (GRAD_W-1)'(gy_q);

  always_ff @(posedge clk_i) begin
    if (state_q == sgt_pkg::S_GRAD) begin
      gx_q <= left_sum - right_sum;
      gy_q <= top_sum - bottom_sum;
    end
    if (state_q == sgt_pkg::S_SQUARE) begin
      sqx_q <= SQ_W'(abs_x) * SQ_W'(abs_x);
      sqy_q <= SQ_W'(abs_y) * SQ_W'(abs_y);
    end
  end

  logic              root_start, root_done;
  logic [GRAD_W-1:0] root;

  sgt_sqrt #(
    .ROOT_W (GRAD_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .value_i (sqx_q + sqy_q),
    .done_o  (root_done),
    .root_o  (root)
  );

  logic [GRAD_W-1:0] thr_scaled, mag_keep;

  assign thr_scaled = GRAD_W'({cfg.threshold, {GRAY_FRACTION_BITS{1'b0}}});
  assign mag_keep   = (root > thr_scaled) ? root : '0;

  logic out_free, out_load;
  logic out_valid_q, out_valid_d;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sgt_pkg::S_IDLE:   if (in_valid_i) state_d = sgt_pkg::S_WIN;
      sgt_pkg::S_WIN:    state_d = result_q ? sgt_pkg::S_GRAD : sgt_pkg::S_IDLE;
      sgt_pkg::S_GRAD:   state_d = sgt_pkg::S_SQUARE;
      sgt_pkg::S_SQUARE: state_d = sgt_pkg::S_SUM;
      sgt_pkg::S_SUM:    state_d = sgt_pkg::S_ROOT;
      sgt_pkg::S_ROOT:   if (root_done) state_d = sgt_pkg::S_DONE;
      sgt_pkg::S_DONE:   if (out_free) state_d = sgt_pkg::S_IDLE;
      default:           state_d = sgt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    root_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      sgt_pkg::S_IDLE: in_ready_o = 1'b1;
      sgt_pkg::S_WIN:  mem_we     = 1'b1;
      sgt_pkg::S_SUM:  root_start = 1'b1;
      sgt_pkg::S_DONE: out_load   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sgt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // output register: hold until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      horizontal_gradient_o <= sgt_pkg::OUT_W'(gx_q);
      vertical_gradient_o   <= sgt_pkg::OUT_W'(gy_q);
      edge_magnitude_o      <= sgt_pkg::OUT_W'(mag_keep);
      frame_last_o          <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_win_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sgt_pkg::S_WIN) |-> $past(in_valid_i && in_ready_o))
    else $error("window step without an accepted pixel");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == sgt_pkg::S_DONE))
    else $error("result raised outside the final step");

  a_border_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sgt_pkg::S_WIN && !result_q) |=> state_q == sgt_pkg::S_IDLE)
    else $error("border pixel entered the gradient path");
`endif

endmodule
